// ===== rtl/core/pmc_pkg.sv =====
// shared types and constants of the pointer motion coalescer
package pmc_pkg;

	localparam int LIMIT_W = 20;
	localparam int ACC_W   = LIMIT_W + 1;

	localparam logic [LIMIT_W-1:0] MOTION_LIMIT_RST = 20'd32767;

	// item codes
	typedef enum logic [1:0] {
		MODE_PUBLISH = 2'd0,
		MODE_TAKE    = 2'd1,
		MODE_RESET   = 2'd2
	} mode_t;

	// result codes
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_MOTION = 2'd1,
		KIND_WHEEL  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] motion_dx;
		logic [15:0] motion_dy;
		logic [15:0] button_bits;
		logic [7:0]  wheel_step;
	} item_t;

	typedef struct packed {
		logic [ACC_W-1:0] x_accum;
		logic [ACC_W-1:0] y_accum;
		logic [15:0]      button_latch;
		logic             motion_pending;
		logic [7:0]       wheel_accum;
		logic             wheel_pending;
	} state_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [15:0] out_dx;
		logic [15:0] out_dy;
		logic [15:0] out_buttons;
		logic [7:0]  out_wheel;
		logic        wake;
	} res_t;

endpackage

// ===== rtl/core/pmc_step.sv =====
// next-state and result logic for one word
module pmc_step import pmc_pkg::*; (
	input  item_t              item,
	input  state_t             st,
	input  logic [LIMIT_W-1:0] limit,
	output state_t             nxt,
	output res_t               res
);

	logic [ACC_W:0] x_sum, y_sum, lim_pos, lim_neg, x_sat, y_sat;
	logic [8:0]     w_sum, w_sat;
	logic [15:0]    x_out, y_out;
	logic           any;

	// saturating motion adds, one guard bit over the accumulator
	assign x_sum   = {st.x_accum[ACC_W-1], st.x_accum}
	               + {{(ACC_W-15){item.motion_dx[15]}}, item.motion_dx};
	assign y_sum   = {st.y_accum[ACC_W-1], st.y_accum}
	               + {{(ACC_W-15){item.motion_dy[15]}}, item.motion_dy};
	assign lim_pos = {2'b00, limit};
	assign lim_neg = -lim_pos;

	assign x_sat = ($signed(x_sum) > $signed(lim_pos)) ? lim_pos :
	               ($signed(x_sum) < $signed(lim_neg)) ? lim_neg : x_sum;
	assign y_sat = ($signed(y_sum) > $signed(lim_pos)) ? lim_pos :
	               ($signed(y_sum) < $signed(lim_neg)) ? lim_neg : y_sum;

	// wheel add, saturating at +-127
	assign w_sum = {st.wheel_accum[7], st.wheel_accum} + {item.wheel_step[7], item.wheel_step};
	assign w_sat = ($signed(w_sum) > 9'sd127)  ? 9'h07f :
	               ($signed(w_sum) < -9'sd127) ? 9'h181 : w_sum;

	// clamp to the 16-bit report range
	assign x_out = ($signed(st.x_accum) > 21'sd32767)  ? 16'h7fff :
	               ($signed(st.x_accum) < -21'sd32768) ? 16'h8000 : st.x_accum[15:0];
	assign y_out = ($signed(st.y_accum) > 21'sd32767)  ? 16'h7fff :
	               ($signed(st.y_accum) < -21'sd32768) ? 16'h8000 : st.y_accum[15:0];

	always_comb begin
		nxt = st;
		res = '0;
		any = 1'b0;
		case (mode_t'(item.mode))
			MODE_PUBLISH: begin
				if (item.motion_dx != 16'd0 || item.motion_dy != 16'd0) begin
					nxt.x_accum        = x_sat[ACC_W-1:0];
					nxt.y_accum        = y_sat[ACC_W-1:0];
					nxt.button_latch   = item.button_bits;
					nxt.motion_pending = 1'b1;
					any                = 1'b1;
				end
				if (item.wheel_step != 8'd0) begin
					nxt.wheel_accum   = w_sat[7:0];
					nxt.wheel_pending = 1'b1;
					any               = 1'b1;
				end
				res.wake = any;
			end
			MODE_TAKE: begin
				if (st.motion_pending) begin
					res.result_kind    = KIND_MOTION;
					res.out_dx         = x_out;
					res.out_dy         = y_out;
					res.out_buttons    = st.button_latch;
					nxt.x_accum        = '0;
					nxt.y_accum        = '0;
					nxt.motion_pending = 1'b0;
				end else if (st.wheel_pending) begin
					res.result_kind   = KIND_WHEEL;
					res.out_wheel     = st.wheel_accum;
					nxt.wheel_accum   = '0;
					nxt.wheel_pending = 1'b0;
				end
			end
			MODE_RESET: begin
				nxt = '0;
			end
			default: begin
				// unused code: no state change, all-zero result
			end
		endcase
	end

endmodule

// ===== rtl/core/pointer_motion_coalescer_core.sv =====
// top level of the pointer motion coalescer
//
//  channel   signals                              direction  moves
//  item      item_valid/item_stall + 5 fields     in         one report or command word
//  result    result_valid/result_stall + 6 fields out        one result word per item word
//  cfg       cfg_valid/cfg_ready + motion_limit   in         motion saturation limit
//
// every item word produces exactly one result word, through the input and output registers
// one word per cycle in and out while result_stall is low; the state update in
// the step logic (saturating add plus priority select) sets the pace
// reset clears the accumulators, pending flags and both stage valids, limit to 32767
// a stalled result holds in the output register while one more word waits in the
// input register; item_stall rises only when both are full
module pointer_motion_coalescer_core import pmc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         mode,
	input  logic [15:0]        motion_dx,
	input  logic [15:0]        motion_dy,
	input  logic [15:0]        button_bits,
	input  logic [7:0]         wheel_step,

	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         result_kind,
	output logic [15:0]        out_dx,
	output logic [15:0]        out_dy,
	output logic [15:0]        out_buttons,
	output logic [7:0]         out_wheel,
	output logic               wake,

	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] motion_limit
);

	// input register stage
	item_t  item_s1;
	logic   item_valid_s1;
	// output register stage
	res_t   res_s2;
	logic   res_valid_s2;
	// coalescing state
	state_t state_q;
	logic [LIMIT_W-1:0] limit_q;

	state_t state_nxt;
	res_t   res_nxt;
	logic   adv, take_in;

	// stage 1 moves on when the output register is empty or being drained
	assign adv        = item_valid_s1 && (!res_valid_s2 || !result_stall);
	assign item_stall = item_valid_s1 && !adv;
	assign take_in    = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= MOTION_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= motion_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take_in) begin
			item_valid_s1 <= 1'b1;
		end else if (adv) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{mode, motion_dx, motion_dy, button_bits, wheel_step};
		end
	end

	pmc_step u_step (
		.item  (item_s1),
		.st    (state_q),
		.limit (limit_q),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	// state commits together with the result, so the next word sees it at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv) begin
			res_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid = res_valid_s2;
	assign result_kind  = res_s2.result_kind;
	assign out_dx       = res_s2.out_dx;
	assign out_dy       = res_s2.out_dy;
	assign out_buttons  = res_s2.out_buttons;
	assign out_wheel    = res_s2.out_wheel;
	assign wake         = res_s2.wake;

	// no motion pending means both motion accumulators are empty
	a_motion_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.motion_pending |-> (state_q.x_accum == '0 && state_q.y_accum == '0))
		else $error("motion accumulators nonzero without pending motion");

	// same for the wheel
	a_wheel_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.wheel_pending |-> state_q.wheel_accum == '0)
		else $error("wheel accumulator nonzero without pending wheel");

	// a report never carries wake, a motion report never carries wheel
	a_report_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != KIND_NONE |->
		!wake && (result_kind != KIND_MOTION || out_wheel == 8'd0))
		else $error("inconsistent report fields");

	// input stalls only with a full input register behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (item_valid_s1 && res_valid_s2 && result_stall))
		else $error("input stalled without backpressure");

endmodule

// ===== test/pointer_motion_coalescer_core_tb.sv =====
// self-checking testbench of the pointer motion coalescer core
module pointer_motion_coalescer_core_tb;
	import pmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// mode 3 has no code in the package, the block treats it as a no-op
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 100;

	// clock, reset and all block inputs start known
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	logic [1:0]         mode         = '0;
	logic [15:0]        motion_dx    = '0;
	logic [15:0]        motion_dy    = '0;
	logic [15:0]        button_bits  = '0;
	logic [7:0]         wheel_step   = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [1:0]         result_kind;
	logic [15:0]        out_dx;
	logic [15:0]        out_dy;
	logic [15:0]        out_buttons;
	logic [7:0]         out_wheel;
	logic               wake;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] motion_limit = '0;

	// one row of the directed table; typed rows carry their own expected word
	typedef struct {
		item_t w;
		bit    typed;
		res_t  r;
	} row_t;

	row_t dir_rows[$];
	res_t report_q[$];   // expected result words, oldest first
	int   errors = 0;
	int   burst_left = 0;

	// predictor state, mirrors the block after reset
	logic [LIMIT_W-1:0] active_limit = MOTION_LIMIT_RST;
	int                 x_sum = 0;
	int                 y_sum = 0;
	logic [15:0]        held_buttons = '0;
	bit                 motion_armed = 1'b0;
	int                 wheel_sum = 0;
	bit                 wheel_armed = 1'b0;

	res_t want_word;
	res_t got_word;

	pointer_motion_coalescer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.motion_dx    (motion_dx),
		.motion_dy    (motion_dy),
		.button_bits  (button_bits),
		.wheel_step   (wheel_step),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.out_dx       (out_dx),
		.out_dy       (out_dy),
		.out_buttons  (out_buttons),
		.out_wheel    (out_wheel),
		.wake         (wake),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.motion_limit (motion_limit)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int clip(input int v, input int lo, input int hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// advance the predictor by one accepted word and return its result word
	function automatic res_t coalesce_step(input item_t w);
		res_t r;
		int   dx;
		int   dy;
		int   wh;
		int   lim;
		r   = '0;
		dx  = int'($signed(w.motion_dx));
		dy  = int'($signed(w.motion_dy));
		wh  = int'($signed(w.wheel_step));
		lim = int'(active_limit);
		if (w.mode == MODE_PUBLISH) begin
			// zero motion leaves accumulators and buttons alone
			if (dx != 0 || dy != 0) begin
				x_sum        = clip(x_sum + dx, -lim, lim);
				y_sum        = clip(y_sum + dy, -lim, lim);
				held_buttons = w.button_bits;
				motion_armed = 1'b1;
			end
			if (wh != 0) begin
				wheel_sum   = clip(wheel_sum + wh, -127, 127);
				wheel_armed = 1'b1;
			end
			r.wake = (dx != 0 || dy != 0 || wh != 0);
		end else if (w.mode == MODE_TAKE) begin
			// motion wins, wheel stays pending behind it
			if (motion_armed) begin
				r.result_kind = KIND_MOTION;
				r.out_dx      = 16'(clip(x_sum, -32768, 32767));
				r.out_dy      = 16'(clip(y_sum, -32768, 32767));
				r.out_buttons = held_buttons;
				x_sum         = 0;
				y_sum         = 0;
				motion_armed  = 1'b0;
			end else if (wheel_armed) begin
				r.result_kind = KIND_WHEEL;
				r.out_wheel   = 8'(wheel_sum);
				wheel_sum     = 0;
				wheel_armed   = 1'b0;
			end
		end else if (w.mode == MODE_RESET) begin
			x_sum        = 0;
			y_sum        = 0;
			held_buttons = '0;
			motion_armed = 1'b0;
			wheel_sum    = 0;
			wheel_armed  = 1'b0;
		end
		return r;
	endfunction

	task automatic add_row(input logic [1:0] m, input logic [15:0] dx, input logic [15:0] dy,
			input logic [15:0] btn, input logic [7:0] wh, input bit typed, input kind_t k,
			input logic [15:0] odx, input logic [15:0] ody, input logic [15:0] obtn,
			input logic [7:0] owh, input logic wk);
		row_t row;
		row.w.mode          = m;
		row.w.motion_dx     = dx;
		row.w.motion_dy     = dy;
		row.w.button_bits   = btn;
		row.w.wheel_step    = wh;
		row.typed           = typed;
		row.r.result_kind   = k;
		row.r.out_dx        = odx;
		row.r.out_dy        = ody;
		row.r.out_buttons   = obtn;
		row.r.out_wheel     = owh;
		row.r.wake          = wk;
		dir_rows.push_back(row);
	endtask

	// motion values lean on zero, the extremes and small steps
	function automatic logic [15:0] random_motion();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = 16'h0000;
			3:       v = 16'h7FFF;
			4:       v = 16'h8000;
			5, 6:    v = 16'($signed($urandom_range(0, 32)) - 16);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [7:0] random_wheel();
		logic [7:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = 8'h00;
			4:          v = 8'h7F;
			5:          v = 8'h80;
			6, 7:       v = 8'($signed($urandom_range(0, 8)) - 4);
			default:    v = 8'($urandom);
		endcase
		return v;
	endfunction

	// mostly publish and take so reports build up between polls
	function automatic item_t random_item();
		item_t w;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 58)
			w.mode = MODE_PUBLISH;
		else if (pick < 90)
			w.mode = MODE_TAKE;
		else if (pick < 95)
			w.mode = MODE_RESET;
		else
			w.mode = MODE_UNUSED;
		w.motion_dx   = random_motion();
		w.motion_dy   = random_motion();
		w.button_bits = 16'($urandom);
		w.wheel_step  = random_wheel();
		return w;
	endfunction

	// offer one word in bursts with idle gaps, book its expected result on acceptance
	task automatic send_item(input item_t w, input bit typed, input res_t typed_res);
		int   gap;
		res_t predicted;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			// only drop valid when a real gap follows
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		item_valid  <= 1'b1;
		mode        <= w.mode;
		motion_dx   <= w.motion_dx;
		motion_dy   <= w.motion_dy;
		button_bits <= w.button_bits;
		wheel_step  <= w.wheel_step;
		do
			@(posedge clk);
		while (item_stall);
		burst_left--;
		predicted = coalesce_step(w);
		report_q.push_back(typed ? typed_res : predicted);
	endtask

	// drop valid and wait until every booked result word has come out
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (report_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// limit is written only with the pipe empty
	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_valid    <= 1'b1;
		motion_limit <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		active_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver stall: stretches of no stall, random, square wave and heavy stall
	initial begin
		int style;
		int len;
		int period;
		int cnt;
		forever begin
			style  = $urandom_range(0, 3);
			len    = $urandom_range(16, 96);
			period = $urandom_range(1, 5);
			for (cnt = 0; cnt < len; cnt++) begin
				@(negedge clk);
				case (style)
					0:       result_stall <= 1'b0;
					1:       result_stall <= ($urandom_range(0, 2) == 0);
					2:       result_stall <= ((cnt / period) % 2 == 1);
					default: result_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// result checker against the oldest expected word
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			got_word.result_kind = kind_t'(result_kind);
			got_word.out_dx      = out_dx;
			got_word.out_dy      = out_dy;
			got_word.out_buttons = out_buttons;
			got_word.out_wheel   = out_wheel;
			got_word.wake        = wake;
			if (report_q.size() == 0) begin
				$display("%0t: result word with none expected, actual %h", $time, got_word);
				errors++;
			end else begin
				want_word = report_q.pop_front();
				check_field("result_kind", 16'(want_word.result_kind), 16'(got_word.result_kind));
				check_field("out_dx", want_word.out_dx, got_word.out_dx);
				check_field("out_dy", want_word.out_dy, got_word.out_dy);
				check_field("out_buttons", want_word.out_buttons, got_word.out_buttons);
				check_field("out_wheel", 16'(want_word.out_wheel), 16'(got_word.out_wheel));
				check_field("wake", 16'(want_word.wake), 16'(got_word.wake));
			end
		end
	end

	// main sequence
	initial begin
		logic [LIMIT_W-1:0] limits[8];
		int                 p;
		int                 n;
		limits[0] = 20'd1;
		limits[1] = 20'd0;          // out of range, accumulators pinned at zero
		limits[2] = 20'hFFFFF;      // widest, exercises the 16 bit output clamp
		limits[3] = 20'd100;
		limits[4] = 20'd40000;
		limits[5] = 20'h10000;
		limits[6] = 20'($urandom_range(1, 1048575));
		limits[7] = MOTION_LIMIT_RST;

		// directed table, reset limit of 32767
		//       mode          dx        dy        btn       wh     typed kind         odx  ody  obtn owh wk
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 1, KIND_NONE, 0, 0, 0, 0, 0);
		// zero motion publish touches nothing
		add_row(MODE_PUBLISH, 16'h0000, 16'h0000, 16'hFFFF, 8'h00, 1, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 1, KIND_NONE, 0, 0, 0, 0, 0);
		// extremes, then saturation at the limit and at the wheel bound
		add_row(MODE_PUBLISH, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h7F, 1, KIND_NONE, 0, 0, 0, 0, 1);
		add_row(MODE_PUBLISH, 16'h7FFF, 16'h8000, 16'hA5A5, 8'h7F, 1, KIND_NONE, 0, 0, 0, 0, 1);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 0, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 0, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 1, KIND_NONE, 0, 0, 0, 0, 0);
		// wheel of -128 clamps to -127
		add_row(MODE_PUBLISH, 16'h0000, 16'h0000, 16'h1234, 8'h80, 1, KIND_NONE, 0, 0, 0, 0, 1);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 0, KIND_NONE, 0, 0, 0, 0, 0);
		// reset item drops pending motion and wheel
		add_row(MODE_PUBLISH, 16'h0005, 16'h0000, 16'h0001, 8'h03, 1, KIND_NONE, 0, 0, 0, 0, 1);
		add_row(MODE_RESET,   16'h7FFF, 16'h8000, 16'hFFFF, 8'h7F, 1, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 1, KIND_NONE, 0, 0, 0, 0, 0);
		// requeue with wheel keeps the latched buttons, motion goes out first
		add_row(MODE_PUBLISH, 16'h0000, 16'hFFFF, 16'h8000, 8'h00, 1, KIND_NONE, 0, 0, 0, 0, 1);
		add_row(MODE_PUBLISH, 16'h0000, 16'h0000, 16'h7FFF, 8'hFF, 1, KIND_NONE, 0, 0, 0, 0, 1);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 0, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 0, KIND_NONE, 0, 0, 0, 0, 0);
		// unused mode is a no-op with an all zero word
		add_row(MODE_UNUSED,  16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 1, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_PUBLISH, 16'h8000, 16'h7FFF, 16'h5A5A, 8'h80, 1, KIND_NONE, 0, 0, 0, 0, 1);
		add_row(MODE_UNUSED,  16'h7FFF, 16'h8000, 16'h0F0F, 8'h7F, 1, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 0, KIND_NONE, 0, 0, 0, 0, 0);
		add_row(MODE_TAKE,    16'h0000, 16'h0000, 16'h0000, 8'h00, 0, KIND_NONE, 0, 0, 0, 0, 0);

		// reset held from the start, released away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
		settle();

		// random phases, one limit each
		for (p = 0; p < 8; p++) begin
			write_limit(limits[p]);
			for (n = 0; n < PHASE_ITEMS; n++)
				send_item(random_item(), 1'b0, '0);
			settle();
		end

		if (errors == 0)
			$display("PASS pointer_motion_coalescer_core");
		else
			$display("FAIL pointer_motion_coalescer_core");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL pointer_motion_coalescer_core");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/pmc_pkg.sv
rtl/core/pmc_step.sv
rtl/core/pointer_motion_coalescer_core.sv
test/pointer_motion_coalescer_core_tb.sv
